// ===== design/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and calendar helper functions for the date adder.
// ----------------------------------------------------------------------------
package cda_pkg;

    // Field widths
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int AMT_W    = 16;
    localparam int DOY_W    = 9;
    localparam int KEY_W    = YEAR_W + MONTH_W + DAY_W;

    // Working widths: year may run past its range before saturation
    localparam int YWORK_W  = 14;
    localparam int REM_W    = 17;
    localparam int CNT_W    = 5;

    // Stream widths, padded to whole bytes
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 12'd4095;
    localparam logic [YEAR_W-1:0]  CYCLE_LEN = 12'd400;
    localparam logic [YEAR_W-1:0]  CYCLE_TOP = 12'd399;
    localparam logic [MONTH_W-1:0] MONTHS    = 4'd12;

    // Mod-400 reduction subtracts 400<<k for k = 3..0
    localparam int MOD_STEPS   = 4;
    localparam int SHIFT_W     = 2;

    // Month total divided by 12: quarter it, then multiply by ceil(2^17 / 3).
    // Exact for a quartered total below 2^17; the product stays below 2^30.
    localparam int               QUOT_W     = 13;
    localparam int               PROD_W     = 30;
    localparam int               DIV3_SHIFT = 17;
    localparam logic [AMT_W-1:0] DIV3_RECIP = 16'd43691;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MOD_STEP,
        OP_FOLD,
        OP_YEAR_STEP,
        OP_MONTH_INIT,
        OP_MONTH_STEP,
        OP_DAY_SET,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_SAT,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic [SHIFT_W-1:0] shift;
    } dp_cmd_t;

    typedef struct packed {
        logic req_months;
        logic year_more;
        logic month_more;
    } dp_status_t;

    // Fold a month code into 1..12
    function automatic logic [MONTH_W-1:0] fold_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        case (m)
            4'd0:    r = 4'd12;
            4'd13:   r = 4'd1;
            4'd14:   r = 4'd2;
            4'd15:   r = 4'd3;
            default: r = m;
        endcase
        return r;
    endfunction

    // Leap test from the year's position in the 400-year cycle
    function automatic logic leap_of(input logic [YEAR_W-1:0] r);
        return (r[1:0] == 2'd0) && (r != 12'd100) && (r != 12'd200) && (r != 12'd300);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:    r = leap ? 5'd29 : 5'd28;
            4'd4:    r = 5'd30;
            4'd6:    r = 5'd30;
            4'd9:    r = 5'd30;
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    // Days in the months before month m
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DOY_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        if (leap && (m > 4'd2)) begin
            r = r + 9'd1;
        end
        return r;
    endfunction

endpackage

// ===== design/cda_datapath.sv =====
// ----------------------------------------------------------------------------
// cda_datapath
// Date registers, year/month walk, divide-by-12 and mod-400 units, result.
// ----------------------------------------------------------------------------
module cda_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cda_pkg::dp_cmd_t               cmd,
    input  logic [cda_pkg::S_DATA_W-1:0]   in_data,
    input  logic                           in_req,
    output cda_pkg::dp_status_t            status,
    output logic [cda_pkg::M_DATA_W-1:0]   out_data,
    output logic                           out_ovf
);

    logic                            req_reg,  req_next;
    logic [cda_pkg::YWORK_W-1:0]     y_reg,    y_next;
    logic [cda_pkg::MONTH_W-1:0]     m_reg,    m_next;
    logic [cda_pkg::DAY_W-1:0]       d_reg,    d_next;
    logic [cda_pkg::AMT_W-1:0]       amt_reg,  amt_next;
    logic [cda_pkg::YEAR_W-1:0]      mod_reg,  mod_next;
    logic [cda_pkg::REM_W-1:0]       rem_reg,  rem_next;
    logic [cda_pkg::QUOT_W-1:0]      quot_reg, quot_next;
    logic                            ovf_reg,  ovf_next;
    logic [cda_pkg::M_DATA_W-1:0]    out_data_reg, out_data_next;
    logic                            out_ovf_reg,  out_ovf_next;

    logic                            leap;
    logic [cda_pkg::DAY_W-1:0]       mlen;
    logic [cda_pkg::DOY_W-1:0]       ylen;
    logic [cda_pkg::DAY_W-1:0]       d_fold;
    logic [cda_pkg::YEAR_W-1:0]      mod_sub;
    logic [cda_pkg::PROD_W-1:0]      div_prod;
    logic [cda_pkg::QUOT_W-1:0]      div_quot;
    logic [cda_pkg::REM_W-1:0]       div_rem;
    logic [cda_pkg::YEAR_W-1:0]      y_sat;
    logic                            y_over;
    logic [cda_pkg::DOY_W-1:0]       doy;
    logic [cda_pkg::KEY_W-1:0]       key;

    // Calendar facts for the current working year and month
    assign leap    = cda_pkg::leap_of(mod_reg);
    assign mlen    = cda_pkg::month_len(m_reg, leap);
    assign ylen    = leap ? 9'd366 : 9'd365;
    assign mod_sub = cda_pkg::CYCLE_LEN << cmd.shift;

    // Fold the day into 1..month length
    always_comb begin
        if (d_reg == 5'd0) begin
            d_fold = mlen;
        end else if (d_reg > mlen) begin
            d_fold = d_reg - mlen;
        end else begin
            d_fold = d_reg;
        end
    end

    // Quotient by 12: quarter the month total, then multiply by the reciprocal of 3
    assign div_prod = cda_pkg::PROD_W'(rem_reg[cda_pkg::REM_W-1:2]) *
                      cda_pkg::PROD_W'(cda_pkg::DIV3_RECIP);
    assign div_quot = div_prod[cda_pkg::DIV3_SHIFT +: cda_pkg::QUOT_W];

    // Remainder from the registered quotient: total minus 8q minus 4q
    assign div_rem  = rem_reg - ((cda_pkg::REM_W'(quot_reg) << 3) +
                                 (cda_pkg::REM_W'(quot_reg) << 2));

    // Saturate the year
    assign y_over = (y_reg > cda_pkg::YWORK_W'(cda_pkg::YEAR_MAX));
    assign y_sat  = y_over ? cda_pkg::YEAR_MAX : y_reg[cda_pkg::YEAR_W-1:0];

    // Result fields
    assign doy = cda_pkg::days_before(m_reg, leap) + cda_pkg::DOY_W'(d_reg);
    assign key = {y_reg[cda_pkg::YEAR_W-1:0], m_reg, d_reg};

    assign status.req_months = req_reg;
    assign status.year_more  = (rem_reg > cda_pkg::REM_W'(ylen));
    assign status.month_more = (m_reg < cda_pkg::MONTHS) &&
                               (rem_reg > cda_pkg::REM_W'(mlen));

    // Apply the current command
    always_comb begin
        req_next      = req_reg;
        y_next        = y_reg;
        m_next        = m_reg;
        d_next        = d_reg;
        amt_next      = amt_reg;
        mod_next      = mod_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        ovf_next      = ovf_reg;
        out_data_next = out_data_reg;
        out_ovf_next  = out_ovf_reg;
        case (cmd.op)
            cda_pkg::OP_LOAD: begin
                req_next = in_req;
                y_next   = cda_pkg::YWORK_W'(in_data[11:0]);
                m_next   = cda_pkg::fold_month(in_data[15:12]);
                d_next   = in_data[20:16];
                amt_next = in_data[36:21];
                mod_next = in_data[11:0];
                ovf_next = 1'b0;
            end
            cda_pkg::OP_MOD_STEP: begin
                if (mod_reg >= mod_sub) begin
                    mod_next = mod_reg - mod_sub;
                end
            end
            cda_pkg::OP_FOLD: begin
                d_next = d_fold;
                if (req_reg) begin
                    rem_next = cda_pkg::REM_W'(m_reg - 4'd1) + cda_pkg::REM_W'(amt_reg);
                end else begin
                    rem_next = cda_pkg::REM_W'(cda_pkg::days_before(m_reg, leap)) +
                               cda_pkg::REM_W'(d_fold) + cda_pkg::REM_W'(amt_reg);
                end
            end
            cda_pkg::OP_YEAR_STEP: begin
                rem_next = rem_reg - cda_pkg::REM_W'(ylen);
                y_next   = y_reg + 14'd1;
                mod_next = (mod_reg == cda_pkg::CYCLE_TOP) ? '0 : mod_reg + 12'd1;
            end
            cda_pkg::OP_MONTH_INIT: begin
                m_next = 4'd1;
            end
            cda_pkg::OP_MONTH_STEP: begin
                rem_next = rem_reg - cda_pkg::REM_W'(mlen);
                m_next   = m_reg + 4'd1;
            end
            cda_pkg::OP_DAY_SET: begin
                d_next = rem_reg[cda_pkg::DAY_W-1:0];
            end
            cda_pkg::OP_DIV_STEP: begin
                quot_next = div_quot;
            end
            cda_pkg::OP_DIV_DONE: begin
                y_next = y_reg + cda_pkg::YWORK_W'(quot_reg);
                m_next = div_rem[cda_pkg::MONTH_W-1:0] + 4'd1;
            end
            cda_pkg::OP_SAT: begin
                y_next   = cda_pkg::YWORK_W'(y_sat);
                mod_next = y_sat;
                ovf_next = y_over;
            end
            cda_pkg::OP_EMIT: begin
                out_data_next = {5'd0, key, doy, d_reg, m_reg, y_reg[cda_pkg::YEAR_W-1:0]};
                out_ovf_next  = ovf_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        y_reg        <= y_next;
        m_reg        <= m_next;
        d_reg        <= d_next;
        amt_reg      <= amt_next;
        mod_reg      <= mod_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        ovf_reg      <= ovf_next;
        out_data_reg <= out_data_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_data = out_data_reg;
    assign out_ovf  = out_ovf_reg;

    // The month is in range once loaded
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == cda_pkg::OP_LOAD |=> (m_reg >= 4'd1) && (m_reg <= cda_pkg::MONTHS))
        else $error("month out of range after load");

    // The month walk leaves a valid day of month
    a_day_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == cda_pkg::OP_DAY_SET |-> (rem_reg != '0) && (rem_reg <= 17'd31))
        else $error("day remainder out of range");

    // The year is in range after saturation
    a_year_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == cda_pkg::OP_SAT |=> y_reg <= cda_pkg::YWORK_W'(cda_pkg::YEAR_MAX))
        else $error("year above range after saturation");

endmodule

// ===== design/cda_ctrl.sv =====
// ----------------------------------------------------------------------------
// cda_ctrl
// Sequencer for the date adder: handshakes, step counts and datapath commands.
// ----------------------------------------------------------------------------
module cda_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  cda_pkg::dp_status_t   status,
    output cda_pkg::dp_cmd_t      cmd
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_MOD_A    = 10'b0000000010,
        ST_FOLD     = 10'b0000000100,
        ST_YEARS    = 10'b0000001000,
        ST_MONTHS   = 10'b0000010000,
        ST_DIV      = 10'b0000100000,
        ST_DIV_DONE = 10'b0001000000,
        ST_SAT      = 10'b0010000000,
        ST_MOD_B    = 10'b0100000000,
        ST_EMIT     = 10'b1000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [cda_pkg::CNT_W-1:0] cnt_reg,   cnt_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    // Next state, step count and command
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.op        = cda_pkg::OP_NONE;
        cmd.shift     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = cda_pkg::OP_LOAD;
                    cnt_next   = cda_pkg::CNT_W'(cda_pkg::MOD_STEPS - 1);
                    state_next = ST_MOD_A;
                end
            end
            ST_MOD_A: begin
                cmd.op    = cda_pkg::OP_MOD_STEP;
                cmd.shift = cnt_reg[cda_pkg::SHIFT_W-1:0];
                if (cnt_reg == '0) begin
                    state_next = ST_FOLD;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_FOLD: begin
                cmd.op = cda_pkg::OP_FOLD;
                if (status.req_months) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_YEARS;
                end
            end
            ST_YEARS: begin
                if (status.year_more) begin
                    cmd.op = cda_pkg::OP_YEAR_STEP;
                end else begin
                    cmd.op     = cda_pkg::OP_MONTH_INIT;
                    state_next = ST_MONTHS;
                end
            end
            ST_MONTHS: begin
                if (status.month_more) begin
                    cmd.op = cda_pkg::OP_MONTH_STEP;
                end else begin
                    cmd.op     = cda_pkg::OP_DAY_SET;
                    state_next = ST_SAT;
                end
            end
            ST_DIV: begin
                cmd.op     = cda_pkg::OP_DIV_STEP;
                state_next = ST_DIV_DONE;
            end
            ST_DIV_DONE: begin
                cmd.op     = cda_pkg::OP_DIV_DONE;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                cmd.op     = cda_pkg::OP_SAT;
                cnt_next   = cda_pkg::CNT_W'(cda_pkg::MOD_STEPS - 1);
                state_next = ST_MOD_B;
            end
            ST_MOD_B: begin
                cmd.op    = cda_pkg::OP_MOD_STEP;
                cmd.shift = cnt_reg[cda_pkg::SHIFT_W-1:0];
                if (cnt_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op        = cda_pkg::OP_EMIT;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // An accepted item starts the year reduction
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_MOD_A)
        else $error("accepted item did not start");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == cda_pkg::OP_EMIT |-> !m_tvalid_reg || m_tready)
        else $error("result overwritten");

    // The quotient step is followed by the remainder step
    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |=> state_reg == ST_DIV_DONE)
        else $error("division did not finish");

endmodule

// ===== design/calendar_date_add.sv =====
// ----------------------------------------------------------------------------
// calendar_date_add
// Gregorian date plus a non-negative number of days or months.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_ channel: s_tuser selects the kind of amount
//   (0 days, 1 months), s_tdata carries the start date and the amount.
//   Each item yields exactly one result item on the m_ channel: the new
//   date, its day of year and packed key in m_tdata, the year overflow flag
//   in m_tuser.
//   One item is worked on at a time. From acceptance to m_tvalid:
//     days:   Y whole years stepped (up to 180 for the largest amount),
//             then M months walked (up to 11); the year walk loop is the longest part.
//     months: the divide by 12 is a reciprocal multiply, a quotient step
//             followed by a remainder step.
//   Both paths include two 4-step mod-400 reductions of the year.
//   s_tready is high while the sequencer is idle, from the cycle after a result
//   is handed over; the next item is taken while that result still waits.
//   If the receiver stalls, the result holds in the output register and the
//   following result waits in the sequencer until that register frees up.
//   Synchronous reset clears the sequencer and drops any pending result.
// ----------------------------------------------------------------------------
module calendar_date_add (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // in_year[11:0], in_month[15:12], in_day[20:16], amount[36:21], zero pad
    input  logic [cda_pkg::S_DATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_year[11:0], out_month[15:12], out_day[20:16], day_of_year[29:21],
    // packed_key[50:30], zero pad
    output logic [cda_pkg::M_DATA_W-1:0] m_tdata,
    // year_overflow[0]
    output logic                         m_tuser
);

    cda_pkg::dp_cmd_t    cmd;
    cda_pkg::dp_status_t status;

    // Sequencer
    cda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Date arithmetic
    cda_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .in_req   (s_tuser),
        .status   (status),
        .out_data (m_tdata),
        .out_ovf  (m_tuser)
    );

endmodule
